@@ src/etvp_pkg.sv @@
// ----------------------------------------------------------------------------
// etvp_pkg: shared types and constants for the exception table varint parser
// Digit layout of a table byte, field sequence codes and the entry record.
// ----------------------------------------------------------------------------
package etvp_pkg;

  // Default width of the running value.
  localparam int unsigned DefaultValueBits = 32;

  // Table byte layout: six payload bits, then the continue bit.
  localparam int unsigned DigitBits = 6;
  localparam int unsigned ContBit   = 6;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned EntryBits = 32;

  // Which of the four values of an entry comes next.
  typedef enum logic [1:0] {
    FIELD_START  = 2'd0,
    FIELD_LENGTH = 2'd1,
    FIELD_TARGET = 2'd2,
    FIELD_DEPTH  = 2'd3
  } field_e;

  // One decoded entry.
  typedef struct packed {
    logic [EntryBits-1:0] start;
    logic [EntryBits-1:0] stop;
    logic [EntryBits-2:0] depth;
    logic                 lasti;
    logic                 overflow;
  } entry_t;

  // Per-byte decode outcome handed to the top level.
  typedef struct packed {
    logic   emit;
    entry_t entry;
  } decode_res_t;

endpackage

@@ src/etvp_decode.sv @@
// ----------------------------------------------------------------------------
// etvp_decode: one-byte step of the varint parser
// Pure next-state logic: folds a byte into the running value and builds the
// entry when the depth value completes.
// ----------------------------------------------------------------------------
module etvp_decode #(
  parameter int unsigned VALUE_BITS = etvp_pkg::DefaultValueBits
) (
  input  logic [etvp_pkg::ByteBits-1:0]  byte_i,
  input  logic                           start_i,
  input  logic [VALUE_BITS-1:0]          accum_i,
  input  logic                           open_i,
  input  etvp_pkg::field_e               field_i,
  input  logic                           ovf_i,
  input  logic [etvp_pkg::EntryBits-1:0] saved_start_i,
  input  logic [etvp_pkg::EntryBits-1:0] saved_end_i,
  output logic [VALUE_BITS-1:0]          accum_o,
  output logic                           open_o,
  output etvp_pkg::field_e               field_o,
  output logic                           ovf_o,
  output logic [etvp_pkg::EntryBits-1:0] saved_start_o,
  output logic [etvp_pkg::EntryBits-1:0] saved_end_o,
  output etvp_pkg::decode_res_t          res_o
);

  localparam int unsigned DB = etvp_pkg::DigitBits;
  localparam int unsigned EB = etvp_pkg::EntryBits;

  logic [VALUE_BITS-1:0] acc_base;
  logic                  open_base;
  etvp_pkg::field_e      field_base;
  logic                  ovf_base;
  logic [DB-1:0]         payload;
  logic [VALUE_BITS-1:0] acc_new;
  logic                  shift_lost;
  logic                  hi_lost;
  logic [EB-1:0]         v32;
  logic [EB:0]           end_sum;
  logic                  ovf_val;

  // Table start wipes the sequence before the byte is taken.
  assign acc_base   = start_i ? '0 : accum_i;
  assign open_base  = start_i ? 1'b0 : open_i;
  assign field_base = start_i ? etvp_pkg::FIELD_START : field_i;
  assign ovf_base   = start_i ? 1'b0 : ovf_i;
  assign payload    = byte_i[DB-1:0];

  assign shift_lost = open_base && (|acc_base[VALUE_BITS-1:VALUE_BITS-DB]);
  assign acc_new    = open_base ? {acc_base[VALUE_BITS-DB-1:0], payload}
                                : {{(VALUE_BITS-DB){1'b0}}, payload};

  if (VALUE_BITS > EB) begin : g_wide
    assign v32     = acc_new[EB-1:0];
    assign hi_lost = |acc_new[VALUE_BITS-1:EB];
  end else if (VALUE_BITS == EB) begin : g_exact
    assign v32     = acc_new;
    assign hi_lost = 1'b0;
  end else begin : g_narrow
    assign v32     = {{(EB-VALUE_BITS){1'b0}}, acc_new};
    assign hi_lost = 1'b0;
  end

  assign end_sum = {1'b0, saved_start_i} + {1'b0, v32} + {{EB{1'b0}}, 1'b1};
  assign ovf_val = ovf_base || shift_lost || hi_lost;

  always_comb begin
    accum_o       = acc_new;
    open_o        = byte_i[etvp_pkg::ContBit];
    field_o       = field_base;
    ovf_o         = ovf_base || shift_lost;
    saved_start_o = saved_start_i;
    saved_end_o   = saved_end_i;
    res_o.emit           = 1'b0;
    res_o.entry.start    = saved_start_i;
    res_o.entry.stop     = saved_end_i;
    res_o.entry.depth    = v32[EB-1:1];
    res_o.entry.lasti    = v32[0];
    res_o.entry.overflow = ovf_val;
    if (!byte_i[etvp_pkg::ContBit]) begin
      ovf_o = ovf_val;
      unique case (field_base)
        etvp_pkg::FIELD_START: begin
          saved_start_o = v32;
          field_o       = etvp_pkg::FIELD_LENGTH;
        end
        etvp_pkg::FIELD_LENGTH: begin
          saved_end_o = end_sum[EB-1:0];
          ovf_o       = ovf_val || end_sum[EB];
          field_o     = etvp_pkg::FIELD_TARGET;
        end
        etvp_pkg::FIELD_TARGET: begin
          field_o = etvp_pkg::FIELD_DEPTH;
        end
        etvp_pkg::FIELD_DEPTH: begin
          res_o.emit = 1'b1;
          field_o    = etvp_pkg::FIELD_START;
          ovf_o      = 1'b0;
        end
        default: begin
          field_o = etvp_pkg::FIELD_START;
        end
      endcase
    end
  end

endmodule

@@ src/exception_table_varint_parser.sv @@
// ----------------------------------------------------------------------------
// exception_table_varint_parser: six-bit varint exception table decoder
// Parses a byte stream of 6-bit varints into (start, end, depth, lasti)
// entries, four values per entry, with a sticky loss flag.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  in      | input     | in_valid_i / in_stall_o | table_byte_i, table_start_i
//  out     | output    | out_valid_o / out_stall_i | entry_start_o, entry_end_o,
//          |           |                        | handler_depth_o, keep_lasti_o,
//          |           |                        | overflow_o
//
// One byte per cycle sustained while the entry side does not stall. A byte
// is held in the input register, then the decode step updates the parser
// state and, on the last byte of an entry, loads the result register. The
// input side stalls only while a byte waits and the result register is
// full and stalled. Reset clears all parser state and both valid flags; no
// sweep is needed after reset.
// ----------------------------------------------------------------------------
module exception_table_varint_parser #(
  parameter int unsigned VALUE_BITS = etvp_pkg::DefaultValueBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // byte stream
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [etvp_pkg::ByteBits-1:0]    table_byte_i,
  input  logic                             table_start_i,
  // entries
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [etvp_pkg::EntryBits-1:0]   entry_start_o,
  output logic [etvp_pkg::EntryBits-1:0]   entry_end_o,
  output logic [etvp_pkg::EntryBits-2:0]   handler_depth_o,
  output logic                             keep_lasti_o,
  output logic                             overflow_o
);

  localparam int unsigned EB = etvp_pkg::EntryBits;

  // Input register
  logic                          s1_valid_q, s1_valid_d;
  logic [etvp_pkg::ByteBits-1:0] s1_byte_q;
  logic                          s1_start_q;

  // Parser state
  logic [VALUE_BITS-1:0] accum_q, accum_d;
  logic                  open_q, open_d;
  etvp_pkg::field_e      field_q, field_d;
  logic                  ovf_q, ovf_d;
  logic [EB-1:0]         saved_start_q, saved_start_d;
  logic [EB-1:0]         saved_end_q, saved_end_d;

  // Result register
  logic                  out_valid_q, out_valid_d;
  etvp_pkg::entry_t      out_entry_q;
  etvp_pkg::decode_res_t dec_res;

  logic out_ready;
  logic in_accept;
  logic s1_fire;
  logic res_load;

  // Result register can take a new entry when empty or being drained.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign res_load   = s1_fire && dec_res.emit;

  etvp_decode #(
    .VALUE_BITS (VALUE_BITS)
  ) u_decode (
    .byte_i        (s1_byte_q),
    .start_i       (s1_start_q),
    .accum_i       (accum_q),
    .open_i        (open_q),
    .field_i       (field_q),
    .ovf_i         (ovf_q),
    .saved_start_i (saved_start_q),
    .saved_end_i   (saved_end_q),
    .accum_o       (accum_d),
    .open_o        (open_d),
    .field_o       (field_d),
    .ovf_o         (ovf_d),
    .saved_start_o (saved_start_d),
    .saved_end_o   (saved_end_d),
    .res_o         (dec_res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = res_load;
    end
  end

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      accum_q       <= '0;
      open_q        <= 1'b0;
      field_q       <= etvp_pkg::FIELD_START;
      ovf_q         <= 1'b0;
      saved_start_q <= '0;
      saved_end_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        accum_q       <= accum_d;
        open_q        <= open_d;
        field_q       <= field_d;
        ovf_q         <= ovf_d;
        saved_start_q <= saved_start_d;
        saved_end_q   <= saved_end_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= table_byte_i;
      s1_start_q <= table_start_i;
    end
    if (res_load) begin
      out_entry_q <= dec_res.entry;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_start_o   = out_entry_q.start;
  assign entry_end_o     = out_entry_q.stop;
  assign handler_depth_o = out_entry_q.depth;
  assign keep_lasti_o    = out_entry_q.lasti;
  assign overflow_o      = out_entry_q.overflow;

  // An emitted entry restarts the field sequence.
  a_emit_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (field_q == etvp_pkg::FIELD_START))
    else $error("field sequence not restarted after entry");

  // Input stalls only with a byte held in the input register.
  a_stall_needs_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // A result leaves only when it was taken.
  a_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_q) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");

  // A result is never overwritten while it waits.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !res_load)
    else $error("result register overwritten");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: exception table varint parser
// Feeds exception-table byte streams (directed corner cases, then random
// well-formed entries mixed with noise and cut-off tables), predicts each
// decoded entry and checks every entry that leaves the block, with random
// gaps on the byte side and random stalls on the entry side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ByteTarget = 1800;

  // One byte of the table stream as the driver sends it.
  typedef struct {
    logic [etvp_pkg::ByteBits-1:0] tbyte;
    logic                          first;
  } table_item_t;

  // Entry decoder mirror plus the queue of entries still to come out.
  class entry_tracker;
    logic [31:0]       acc;
    etvp_pkg::field_e  next_field;
    logic [31:0]       pend_start;
    logic [31:0]       pend_end;
    logic              lost_bits;
    logic              in_value;
    etvp_pkg::entry_t  awaited_entries[$];
    int unsigned       failures;

    function new();
      acc        = '0;
      next_field = etvp_pkg::FIELD_START;
      pend_start = '0;
      pend_end   = '0;
      lost_bits  = 1'b0;
      in_value   = 1'b0;
      failures   = 0;
    endfunction

    // Called for every byte the block accepts.
    function void note_byte(logic [etvp_pkg::ByteBits-1:0] tbyte, logic first);
      logic [32:0]      sum;
      etvp_pkg::entry_t e;
      if (first) begin
        acc        = '0;
        in_value   = 1'b0;
        next_field = etvp_pkg::FIELD_START;
        lost_bits  = 1'b0;
      end
      if (in_value) begin
        // digits pushed past the top are lost
        if ((acc >> (32 - etvp_pkg::DigitBits)) != 0) lost_bits = 1'b1;
        acc = (acc << etvp_pkg::DigitBits) | 32'(tbyte[etvp_pkg::DigitBits-1:0]);
      end else begin
        acc = 32'(tbyte[etvp_pkg::DigitBits-1:0]);
      end
      in_value = tbyte[etvp_pkg::ContBit];
      if (in_value) return;
      case (next_field)
        etvp_pkg::FIELD_START: begin
          pend_start = acc;
          next_field = etvp_pkg::FIELD_LENGTH;
        end
        etvp_pkg::FIELD_LENGTH: begin
          sum = {1'b0, pend_start} + {1'b0, acc} + 33'd1;
          if (sum[32]) lost_bits = 1'b1;
          pend_end   = sum[31:0];
          next_field = etvp_pkg::FIELD_TARGET;
        end
        etvp_pkg::FIELD_TARGET: begin
          next_field = etvp_pkg::FIELD_DEPTH;
        end
        default: begin
          e.start    = pend_start;
          e.stop     = pend_end;
          e.depth    = acc[31:1];
          e.lasti    = acc[0];
          e.overflow = lost_bits;
          awaited_entries.push_back(e);
          next_field = etvp_pkg::FIELD_START;
          lost_bits  = 1'b0;
        end
      endcase
    endfunction

    // Called for every entry the block hands over.
    function void check_entry(etvp_pkg::entry_t got);
      etvp_pkg::entry_t want;
      if (awaited_entries.size() == 0) begin
        $error("unexpected entry: start %h end %h", got.start, got.stop);
        failures++;
        return;
      end
      want = awaited_entries.pop_front();
      if (got.start !== want.start) begin
        $error("entry_start: expected %h, got %h", want.start, got.start);
        failures++;
      end
      if (got.stop !== want.stop) begin
        $error("entry_end: expected %h, got %h", want.stop, got.stop);
        failures++;
      end
      if (got.depth !== want.depth) begin
        $error("handler_depth: expected %h, got %h", want.depth, got.depth);
        failures++;
      end
      if (got.lasti !== want.lasti) begin
        $error("keep_lasti: expected %b, got %b", want.lasti, got.lasti);
        failures++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
        failures++;
      end
    endfunction

    function int waiting();
      return awaited_entries.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [etvp_pkg::ByteBits-1:0]  table_byte_i;
  logic                           table_start_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [etvp_pkg::EntryBits-1:0] entry_start_o;
  logic [etvp_pkg::EntryBits-1:0] entry_end_o;
  logic [etvp_pkg::EntryBits-2:0] handler_depth_o;
  logic                           keep_lasti_o;
  logic                           overflow_o;

  exception_table_varint_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .table_byte_i   (table_byte_i),
    .table_start_i  (table_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_start_o  (entry_start_o),
    .entry_end_o    (entry_end_o),
    .handler_depth_o(handler_depth_o),
    .keep_lasti_o   (keep_lasti_o),
    .overflow_o     (overflow_o)
  );

  entry_tracker tracker = new();
  table_item_t  table_items[$];
  int unsigned  cycles;
  int unsigned  calm_bytes;
  int unsigned  stall_left;
  int unsigned  free_left;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost entry ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Entry side back-pressure: mostly short stalls, a few long ones,
  // and now and then a long stretch with none at all.
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (free_left > 0) begin
      free_left   <= free_left - 1;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (r < 3) begin
      free_left   <= $urandom_range(30, 150);
      out_stall_i <= 1'b0;
    end else if (r < 70) begin
      out_stall_i <= 1'b0;
    end else if (r < 95) begin
      stall_left  <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      stall_left  <= $urandom_range(5, 40);
      out_stall_i <= 1'b1;
    end
  end

  // Entry monitor: values read here are those present at the edge.
  always @(posedge clk_i) begin
    etvp_pkg::entry_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.start    = entry_start_o;
      got.stop     = entry_end_o;
      got.depth    = handler_depth_o;
      got.lasti    = keep_lasti_o;
      got.overflow = overflow_o;
      tracker.check_entry(got);
    end
  end

  // Smallest number of six-bit digits that holds v.
  function automatic int digits_for(logic [63:0] v);
    int n;
    n = 1;
    while (n < 10 && (v >> (etvp_pkg::DigitBits * n)) != 0) n++;
    return n;
  endfunction

  // Append one value as ndig digits, most significant first; bit 7 random.
  task automatic add_value(logic [63:0] val, int ndig, logic first);
    table_item_t item;
    for (int i = ndig - 1; i >= 0; i--) begin
      item.tbyte[7]                 = 1'($urandom_range(0, 1));
      item.tbyte[etvp_pkg::ContBit] = (i != 0);
      item.tbyte[5:0]               = 6'(val >> (etvp_pkg::DigitBits * i));
      item.first                    = first && (i == ndig - 1);
      table_items.push_back(item);
    end
  endtask

  task automatic add_entry(logic [63:0] s, logic [63:0] l, logic [63:0] t,
                           logic [63:0] d, logic first);
    add_value(s, digits_for(s), first);
    add_value(l, digits_for(l), 1'b0);
    add_value(t, digits_for(t), 1'b0);
    add_value(d, digits_for(d), 1'b0);
  endtask

  // Random value: mostly one or two digits, some full width, a few too wide.
  task automatic add_random_value(logic first);
    int unsigned r;
    int          ndig;
    logic [63:0] val;
    r   = $urandom_range(0, 99);
    val = {$urandom(), $urandom()};
    if (r < 50)      ndig = 1;
    else if (r < 75) ndig = $urandom_range(2, 3);
    else if (r < 93) ndig = $urandom_range(4, 6);
    else             ndig = $urandom_range(7, 10);
    if (ndig * etvp_pkg::DigitBits < 64) begin
      val &= (64'd1 << (ndig * etvp_pkg::DigitBits)) - 1;
    end
    add_value(val, ndig, first);
  endtask

  task automatic build_stimulus();
    table_item_t item;
    int unsigned r;
    int          nvals;
    // all-zero entry opening a table
    add_entry(0, 0, 0, 0, 1'b1);
    // largest end without carry, largest depth with lasti set
    add_entry(32'hFFFF_FFFE, 0, 0, 32'hFFFF_FFFF, 1'b0);
    // end carry from start, then from length
    add_entry(32'hFFFF_FFFF, 0, 63, 2, 1'b0);
    add_entry(0, 32'hFFFF_FFFF, 0, 1, 1'b0);
    // start too wide: high digits drop out
    add_value(64'h3FF_FFFF_FFFF, 7, 1'b0);
    add_value(1, 1, 1'b0);
    add_value(0, 1, 1'b0);
    add_value(6, 1, 1'b0);
    // target one bit past 32 bits still flags the entry
    add_value(5, 1, 1'b0);
    add_value(7, 1, 1'b0);
    add_value(64'h1_0000_0000, 6, 1'b0);
    add_value(8, 1, 1'b0);
    // leading zero digits are harmless, even many of them
    add_value(63, 10, 1'b0);
    add_value(2, 3, 1'b0);
    add_value(0, 1, 1'b0);
    add_value(3, 2, 1'b0);
    // new table in the middle of an entry drops the partial one
    add_value(9, 1, 1'b0);
    add_value(9, 1, 1'b0);
    add_entry(1, 2, 3, 4, 1'b1);
    // new table in the middle of a value
    item.tbyte = 8'hC5;
    item.first = 1'b0;
    table_items.push_back(item);
    add_entry(3, 4, 5, 6, 1'b1);

    // Random part: mostly whole entries, some noise, some cut-off tables.
    while (table_items.size() < ByteTarget) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        add_random_value($urandom_range(0, 99) < 5);
        for (int k = 0; k < 3; k++) add_random_value(1'b0);
      end else if (r < 95) begin
        for (int k = $urandom_range(1, 6); k > 0; k--) begin
          item.tbyte = 8'($urandom());
          item.first = ($urandom_range(0, 9) == 0);
          table_items.push_back(item);
        end
      end else begin
        nvals = $urandom_range(1, 3);
        for (int k = 0; k < nvals; k++) add_random_value(1'b0);
        add_random_value(1'b1);
        for (int k = 0; k < 3; k++) add_random_value(1'b0);
      end
    end
    // trailing partial entry: never completes
    add_value(1, 1, 1'b0);
    add_value(2, 1, 1'b0);
  endtask

  // Idle cycles before the next byte: mostly none or a few, sometimes many.
  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm_bytes > 0) begin
      calm_bytes--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_bytes = $urandom_range(20, 120);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_stream();
    int unsigned gap;
    foreach (table_items[k]) begin
      gap = next_gap();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      table_byte_i  <= table_items[k].tbyte;
      table_start_i <= table_items[k].first;
      // hold the byte until an edge sees it taken
      do @(posedge clk_i); while (in_stall_o);
      tracker.note_byte(table_items[k].tbyte, table_items[k].first);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    table_byte_i  = '0;
    table_start_i = 1'b0;
    out_stall_i   = 1'b0;
    cycles        = 0;
    calm_bytes    = 0;
    stall_left    = 0;
    free_left     = 0;
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_stream();
    while (tracker.waiting() != 0) @(posedge clk_i);
    // margin past the input and result registers so a stray extra entry gets caught
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.waiting() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
